[design/mbhn_pkg.sv]
package mbhn_pkg;

  // field widths
  localparam int BTN_W      = 6;
  localparam int COORD_W    = 10;
  localparam int SET_W      = 2;
  localparam int LINK_W     = 4 * BTN_W;
  localparam int BOX_W      = 4 * COORD_W;
  localparam int ENTRY_W    = BOX_W + SET_W;
  localparam int WORD_W     = 32;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;

  // default table size and queue depth
  localparam int MAX_BUTTONS_DEF = 36;
  localparam int QUEUE_DEPTH     = 2;

  // request codes on req_type
  localparam logic [REQ_W-1:0] REQ_LOAD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UP       = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DOWN     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LEFT     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RIGHT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SELECT   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_POINT    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_ACTIVATE = 3'd7;

  // internal operation classes
  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_MOVE     = 3'd1;
  localparam logic [2:0] OP_SELECT   = 3'd2;
  localparam logic [2:0] OP_POINT    = 3'd3;
  localparam logic [2:0] OP_ACTIVATE = 3'd4;

  // move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_PAL_ONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_PAL_TWO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_PAL_THREE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_PAL_ONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_PAL_TWO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_PAL_THREE = 3'd7;

  // classified transaction passed from front to back
  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         dir;
    logic [BTN_W-1:0]   idx;
    logic               loadable;
    logic [LINK_W-1:0]  links;
    logic [BOX_W-1:0]   box;
    logic [SET_W-1:0]   set;
  } job_t;

endpackage

[design/menu_button_highlight_navigator.sv]
// Menu button highlight navigator.
// Input channel (in_valid/in_stall) takes one request per transaction: load a
// table entry, move up/down/left/right, select a number, point, or activate.
// Output channel (out_valid/out_stall) returns exactly one result per request
// with status, current button and the latched box, palette and time stamp.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// A load or a request rejected at once gets its result as it leaves the queue;
// select number and activate read the button's entry, then latch it; a move
// reads the current button's links, then the target's entry (unless the link
// is out of range); a point scans the entries up to the effective button
// count, one table entry per cycle, then reads and latches the hit, if any.
// One request is executed at a time; a two-entry queue in front accepts
// further requests meanwhile.
// When the receiver stalls, the result holds; the back end stops taking work
// and the queue fills, then in_stall rises.
// Reset clears the queue, the sequencer, the highlight state and all
// configuration registers; the button tables are undefined until loaded.
module menu_button_highlight_navigator
  import mbhn_pkg::*;
#(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [BTN_W-1:0]     button_index,
  input  logic [BTN_W-1:0]     link_up,
  input  logic [BTN_W-1:0]     link_down,
  input  logic [BTN_W-1:0]     link_left,
  input  logic [BTN_W-1:0]     link_right,
  input  logic [COORD_W-1:0]   box_x_start,
  input  logic [COORD_W-1:0]   box_y_start,
  input  logic [COORD_W-1:0]   box_x_end,
  input  logic [COORD_W-1:0]   box_y_end,
  input  logic [SET_W-1:0]     color_set,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [BTN_W-1:0]     current_button,
  output logic [COORD_W-1:0]   hl_x_start,
  output logic [COORD_W-1:0]   hl_y_start,
  output logic [COORD_W-1:0]   hl_x_end,
  output logic [COORD_W-1:0]   hl_y_end,
  output logic [WORD_W-1:0]    hl_palette,
  output logic [WORD_W-1:0]    hl_time,
  output logic                 hl_changed,
  output logic                 activated,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic push, q_full, q_valid, q_pop;
  job_t push_job, head_job;

  // request decode
  mbhn_front #(
    .MAX_BUTTONS(MAX_BUTTONS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .button_index (button_index),
    .link_up      (link_up),
    .link_down    (link_down),
    .link_left    (link_left),
    .link_right   (link_right),
    .box_x_start  (box_x_start),
    .box_y_start  (box_y_start),
    .box_x_end    (box_x_end),
    .box_y_end    (box_y_end),
    .color_set    (color_set),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  // request queue
  mbhn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // execution and result register
  mbhn_back #(
    .MAX_BUTTONS(MAX_BUTTONS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .current_button (current_button),
    .hl_x_start     (hl_x_start),
    .hl_y_start     (hl_y_start),
    .hl_x_end       (hl_x_end),
    .hl_y_end       (hl_y_end),
    .hl_palette     (hl_palette),
    .hl_time        (hl_time),
    .hl_changed     (hl_changed),
    .activated      (activated)
  );

endmodule

[design/mbhn_front.sv]
module mbhn_front
  import mbhn_pkg::*;
#(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [BTN_W-1:0]   button_index,
  input  logic [BTN_W-1:0]   link_up,
  input  logic [BTN_W-1:0]   link_down,
  input  logic [BTN_W-1:0]   link_left,
  input  logic [BTN_W-1:0]   link_right,
  input  logic [COORD_W-1:0] box_x_start,
  input  logic [COORD_W-1:0] box_y_start,
  input  logic [COORD_W-1:0] box_x_end,
  input  logic [COORD_W-1:0] box_y_end,
  input  logic [SET_W-1:0]   color_set,
  input  logic               q_full,
  output logic               push,
  output job_t               job
);

  assign push     = in_valid && !q_full;
  assign in_stall = q_full;

  // classify the request
  always_comb begin
    job.dir = DIR_UP;
    case (req_type)
      REQ_LOAD:     job.op = OP_LOAD;
      REQ_UP: begin
        job.op  = OP_MOVE;
        job.dir = DIR_UP;
      end
      REQ_DOWN: begin
        job.op  = OP_MOVE;
        job.dir = DIR_DOWN;
      end
      REQ_LEFT: begin
        job.op  = OP_MOVE;
        job.dir = DIR_LEFT;
      end
      REQ_RIGHT: begin
        job.op  = OP_MOVE;
        job.dir = DIR_RIGHT;
      end
      REQ_SELECT:   job.op = OP_SELECT;
      REQ_POINT:    job.op = OP_POINT;
      REQ_ACTIVATE: job.op = OP_ACTIVATE;
      default:      job.op = OP_LOAD;
    endcase
    job.idx      = button_index;
    job.loadable = (button_index != '0) && (button_index <= BTN_W'(MAX_BUTTONS));
    job.links    = {link_right, link_left, link_down, link_up};
    job.box      = {box_y_end, box_x_end, box_y_start, box_x_start};
    job.set      = color_set;
  end

endmodule

[design/mbhn_queue.sv]
module mbhn_queue
  import mbhn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  // pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

[design/mbhn_back.sv]
module mbhn_back
  import mbhn_pkg::*;
#(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 q_valid,
  input  job_t                 q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [BTN_W-1:0]     current_button,
  output logic [COORD_W-1:0]   hl_x_start,
  output logic [COORD_W-1:0]   hl_y_start,
  output logic [COORD_W-1:0]   hl_x_end,
  output logic [COORD_W-1:0]   hl_y_end,
  output logic [WORD_W-1:0]    hl_palette,
  output logic [WORD_W-1:0]    hl_time,
  output logic                 hl_changed,
  output logic                 activated
);

  localparam int ADDR_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int CNT_W  = $clog2(MAX_BUTTONS + 2);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LINK  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_LATCH = 2'd3;

  // configuration registers
  logic [BTN_W-1:0]  cfg_count;
  logic [WORD_W-1:0] cfg_time;
  logic [WORD_W-1:0] sel_pal_one, sel_pal_two, sel_pal_three;
  logic [WORD_W-1:0] act_pal_one, act_pal_two, act_pal_three;

  // button tables
  logic [LINK_W-1:0]  link_mem [MAX_BUTTONS];
  logic [ENTRY_W-1:0] box_mem  [MAX_BUTTONS];
  logic [LINK_W-1:0]  link_rd;
  logic [ENTRY_W-1:0] box_rd;

  // highlight state
  logic [BTN_W-1:0]  current;
  logic [BOX_W-1:0]  box_reg;
  logic [WORD_W-1:0] palette;
  logic [WORD_W-1:0] time_reg;

  // sequencer state
  logic [1:0]       state, state_next;
  job_t             job;
  logic [BTN_W-1:0] sel_b, sel_b_next;
  logic             act, act_next;
  logic [CNT_W-1:0] scan_b, scan_b_next;
  logic [BTN_W-1:0] cmp_b, cmp_b_next;
  logic [BTN_W-1:0] hit_b, hit_b_next;

  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                res_fire, res_changed, res_act, latch;
  logic [STATUS_W-1:0] res_status;
  logic [BTN_W-1:0]    eff_count, target;
  logic                hit;
  logic [WORD_W-1:0]   lat_pal;
  logic [BTN_W-1:0]    cur_next;
  logic [BOX_W-1:0]    box_next;
  logic [WORD_W-1:0]   pal_next;
  logic [WORD_W-1:0]   time_next;

  function automatic logic [ADDR_W-1:0] slot(input logic [BTN_W-1:0] b);
    logic [BTN_W-1:0] d;
    d = b - BTN_W'(1);
    return ADDR_W'(d);
  endfunction

  function automatic logic in_range(input logic [BTN_W-1:0] b,
                                    input logic [BTN_W-1:0] n);
    return (b != '0) && (b <= n);
  endfunction

  assign eff_count = (cfg_count > BTN_W'(MAX_BUTTONS)) ? BTN_W'(MAX_BUTTONS) : cfg_count;

  // neighbour link of the current button
  always_comb begin
    case (job.dir)
      DIR_UP:    target = link_rd[BTN_W-1:0];
      DIR_DOWN:  target = link_rd[2*BTN_W-1:BTN_W];
      DIR_LEFT:  target = link_rd[3*BTN_W-1:2*BTN_W];
      DIR_RIGHT: target = link_rd[4*BTN_W-1:3*BTN_W];
      default:   target = link_rd[BTN_W-1:0];
    endcase
  end

  // box hit test on the entry read during the scan
  assign hit = (job.box[COORD_W-1:0] >= box_rd[COORD_W-1:0])
            && (job.box[COORD_W-1:0] <= box_rd[3*COORD_W-1:2*COORD_W])
            && (job.box[2*COORD_W-1:COORD_W] >= box_rd[2*COORD_W-1:COORD_W])
            && (job.box[2*COORD_W-1:COORD_W] <= box_rd[4*COORD_W-1:3*COORD_W])
            && (cmp_b != current);

  // palette for the entry being latched
  always_comb begin
    case (box_rd[ENTRY_W-1:BOX_W])
      2'd1:    lat_pal = act ? act_pal_one   : sel_pal_one;
      2'd2:    lat_pal = act ? act_pal_two   : sel_pal_two;
      2'd3:    lat_pal = act ? act_pal_three : sel_pal_three;
      default: lat_pal = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next  = state;
    sel_b_next  = sel_b;
    act_next    = act;
    scan_b_next = scan_b;
    cmp_b_next  = cmp_b;
    hit_b_next  = hit_b;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = slot(q_job.idx);
    q_pop       = 1'b0;
    res_fire    = 1'b0;
    res_status  = ST_OK;
    res_changed = 1'b0;
    res_act     = 1'b0;
    latch       = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && (!out_valid || !out_stall)) begin
          q_pop = 1'b1;
          case (q_job.op)
            OP_LOAD: begin
              res_fire = 1'b1;
              if (q_job.loadable) begin
                wr_en = 1'b1;
              end else begin
                res_status = ST_RANGE;
              end
            end
            OP_MOVE: begin
              if (current == '0) begin
                res_fire   = 1'b1;
                res_status = ST_NONE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = slot(current);
                state_next = S_LINK;
              end
            end
            OP_SELECT: begin
              if (in_range(q_job.idx, eff_count)) begin
                rd_en      = 1'b1;
                rd_addr    = slot(q_job.idx);
                sel_b_next = q_job.idx;
                act_next   = 1'b0;
                state_next = S_LATCH;
              end else begin
                res_fire   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            OP_POINT: begin
              scan_b_next = CNT_W'(1);
              cmp_b_next  = '0;
              hit_b_next  = '0;
              state_next  = S_SCAN;
            end
            OP_ACTIVATE: begin
              if (current == '0) begin
                res_fire   = 1'b1;
                res_status = ST_NONE;
              end else if (in_range(current, eff_count)) begin
                rd_en      = 1'b1;
                rd_addr    = slot(current);
                sel_b_next = current;
                act_next   = 1'b1;
                state_next = S_LATCH;
              end else begin
                res_fire   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      S_LINK: begin
        if (in_range(target, eff_count)) begin
          rd_en      = 1'b1;
          rd_addr    = slot(target);
          sel_b_next = target;
          act_next   = 1'b0;
          state_next = S_LATCH;
        end else begin
          res_fire   = 1'b1;
          res_status = ST_RANGE;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, issue the next read
        if ((cmp_b != '0) && hit) begin
          hit_b_next = cmp_b;
        end
        if (scan_b <= CNT_W'(eff_count)) begin
          rd_en       = 1'b1;
          rd_addr     = ADDR_W'(scan_b - CNT_W'(1));
          cmp_b_next  = BTN_W'(scan_b);
          scan_b_next = scan_b + CNT_W'(1);
        end else begin
          cmp_b_next = '0;
          if (cmp_b == '0) begin
            if (hit_b != '0) begin
              rd_en      = 1'b1;
              rd_addr    = slot(hit_b);
              sel_b_next = hit_b;
              act_next   = 1'b0;
              state_next = S_LATCH;
            end else begin
              res_fire   = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      S_LATCH: begin
        latch       = 1'b1;
        res_fire    = 1'b1;
        res_changed = 1'b1;
        res_act     = act;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // highlight values after this step
  assign cur_next  = latch ? sel_b : current;
  assign box_next  = latch ? box_rd[BOX_W-1:0] : box_reg;
  assign pal_next  = latch ? lat_pal : palette;
  assign time_next = latch ? cfg_time : time_reg;

  // control, configuration and highlight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      current       <= '0;
      box_reg       <= '0;
      palette       <= '0;
      time_reg      <= '0;
      cfg_count     <= '0;
      cfg_time      <= '0;
      sel_pal_one   <= '0;
      sel_pal_two   <= '0;
      sel_pal_three <= '0;
      act_pal_one   <= '0;
      act_pal_two   <= '0;
      act_pal_three <= '0;
    end else begin
      state    <= state_next;
      current  <= cur_next;
      box_reg  <= box_next;
      palette  <= pal_next;
      time_reg <= time_next;
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BUTTON_COUNT:  cfg_count     <= cfg_data[BTN_W-1:0];
          REG_START_TIME:    cfg_time      <= cfg_data;
          REG_SEL_PAL_ONE:   sel_pal_one   <= cfg_data;
          REG_SEL_PAL_TWO:   sel_pal_two   <= cfg_data;
          REG_SEL_PAL_THREE: sel_pal_three <= cfg_data;
          REG_ACT_PAL_ONE:   act_pal_one   <= cfg_data;
          REG_ACT_PAL_TWO:   act_pal_two   <= cfg_data;
          REG_ACT_PAL_THREE: act_pal_three <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    sel_b  <= sel_b_next;
    act    <= act_next;
    scan_b <= scan_b_next;
    cmp_b  <= cmp_b_next;
    hit_b  <= hit_b_next;
    if (q_pop) begin
      job <= q_job;
    end
  end

  // table memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= q_job.links;
      box_mem[wr_addr]  <= {q_job.set, q_job.box};
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
      box_rd  <= box_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_fire) begin
      status         <= res_status;
      current_button <= cur_next;
      hl_x_start     <= box_next[COORD_W-1:0];
      hl_y_start     <= box_next[2*COORD_W-1:COORD_W];
      hl_x_end       <= box_next[3*COORD_W-1:2*COORD_W];
      hl_y_end       <= box_next[4*COORD_W-1:3*COORD_W];
      hl_palette     <= pal_next;
      hl_time        <= time_next;
      hl_changed     <= res_changed;
      activated      <= res_act;
    end
  end

endmodule

[bench/tb_menu_button_highlight_navigator.sv]
module tb_menu_button_highlight_navigator;
  timeunit 1ns;
  timeprecision 1ps;

  import mbhn_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 70;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [BTN_W-1:0]   button;
    logic [BTN_W-1:0]   go_up;
    logic [BTN_W-1:0]   go_down;
    logic [BTN_W-1:0]   go_left;
    logic [BTN_W-1:0]   go_right;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [SET_W-1:0]   set;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BTN_W-1:0]    button;
    logic [COORD_W-1:0]  xs;
    logic [COORD_W-1:0]  ys;
    logic [COORD_W-1:0]  xe;
    logic [COORD_W-1:0]  ye;
    logic [WORD_W-1:0]   palette;
    logic [WORD_W-1:0]   stamp;
    logic                changed;
    logic                fired;
  } highlight_t;

  typedef struct packed {
    logic [BTN_W-1:0]   go_up;
    logic [BTN_W-1:0]   go_down;
    logic [BTN_W-1:0]   go_left;
    logic [BTN_W-1:0]   go_right;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [SET_W-1:0]   set;
  } button_t;

  typedef struct {
    request_t   rq;
    bit         typed;
    highlight_t want;
  } row_t;

  // clock, reset and block ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = '0;
  logic [BTN_W-1:0]     button_index = '0;
  logic [BTN_W-1:0]     link_up = '0;
  logic [BTN_W-1:0]     link_down = '0;
  logic [BTN_W-1:0]     link_left = '0;
  logic [BTN_W-1:0]     link_right = '0;
  logic [COORD_W-1:0]   box_x_start = '0;
  logic [COORD_W-1:0]   box_y_start = '0;
  logic [COORD_W-1:0]   box_x_end = '0;
  logic [COORD_W-1:0]   box_y_end = '0;
  logic [SET_W-1:0]     color_set = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [BTN_W-1:0]     current_button;
  logic [COORD_W-1:0]   hl_x_start;
  logic [COORD_W-1:0]   hl_y_start;
  logic [COORD_W-1:0]   hl_x_end;
  logic [COORD_W-1:0]   hl_y_end;
  logic [WORD_W-1:0]    hl_palette;
  logic [WORD_W-1:0]    hl_time;
  logic                 hl_changed;
  logic                 activated;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  // predictor state: button table, highlight and registers
  button_t          buttons [1:MAX_BUTTONS_DEF];
  bit               loaded [1:MAX_BUTTONS_DEF];
  logic [BTN_W-1:0] cur_btn = '0;
  logic [COORD_W-1:0] lit_xs = '0, lit_ys = '0, lit_xe = '0, lit_ye = '0;
  logic [WORD_W-1:0] lit_palette = '0;
  logic [WORD_W-1:0] lit_stamp = '0;
  logic [BTN_W-1:0] btn_count = '0;
  logic [WORD_W-1:0] start_stamp = '0;
  logic [WORD_W-1:0] sel_pal [1:3] = '{'0, '0, '0};
  logic [WORD_W-1:0] act_pal [1:3] = '{'0, '0, '0};

  highlight_t awaited_highlights [$];
  int         errors = 0;
  int         quiet_cycles = 0;
  int         idle_pct = 14;

  menu_button_highlight_navigator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // buttons in use, capped at table size
  function automatic int unsigned live_buttons();
    return (btn_count > MAX_BUTTONS_DEF) ? MAX_BUTTONS_DEF : int'(btn_count);
  endfunction

  // latch box, palette and time of a button, range checked
  function automatic logic [STATUS_W-1:0] highlight(input int unsigned b, input bit action);
    logic [SET_W-1:0] cs;
    if (b == 0 || b > live_buttons()) return ST_RANGE;
    cs = buttons[b].set;
    cur_btn = BTN_W'(b);
    lit_xs = buttons[b].xs;
    lit_ys = buttons[b].ys;
    lit_xe = buttons[b].xe;
    lit_ye = buttons[b].ye;
    if (cs == 0) lit_palette = '0;
    else lit_palette = action ? act_pal[cs] : sel_pal[cs];
    lit_stamp = start_stamp;
    return ST_OK;
  endfunction

  // expected result of one request, advancing the predictor state
  function automatic highlight_t navigate(input request_t r);
    highlight_t res;
    int unsigned origin, hit, target, b;
    res = '0;
    res.status = ST_OK;
    case (r.kind)
      REQ_LOAD: begin
        if (r.button >= 1 && r.button <= MAX_BUTTONS_DEF) begin
          buttons[r.button] = '{r.go_up, r.go_down, r.go_left, r.go_right,
                                r.xs, r.ys, r.xe, r.ye, r.set};
          loaded[r.button] = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      REQ_UP, REQ_DOWN, REQ_LEFT, REQ_RIGHT: begin
        if (cur_btn == 0) begin
          res.status = ST_NONE;
        end else begin
          target = (r.kind == REQ_UP)   ? buttons[cur_btn].go_up :
                   (r.kind == REQ_DOWN) ? buttons[cur_btn].go_down :
                   (r.kind == REQ_LEFT) ? buttons[cur_btn].go_left :
                                          buttons[cur_btn].go_right;
          res.status = highlight(target, 1'b0);
          res.changed = (res.status == ST_OK);
        end
      end
      REQ_SELECT: begin
        res.status = highlight(r.button, 1'b0);
        res.changed = (res.status == ST_OK);
      end
      REQ_POINT: begin
        origin = cur_btn;
        hit = 0;
        for (b = 1; b <= live_buttons(); b++) begin
          if (r.xs >= buttons[b].xs && r.xs <= buttons[b].xe &&
              r.ys >= buttons[b].ys && r.ys <= buttons[b].ye && b != origin)
            hit = b;
        end
        if (hit != 0) begin
          res.status = highlight(hit, 1'b0);
          res.changed = (res.status == ST_OK);
        end
      end
      REQ_ACTIVATE: begin
        if (cur_btn == 0) begin
          res.status = ST_NONE;
        end else begin
          res.status = highlight(cur_btn, 1'b1);
          res.changed = (res.status == ST_OK);
          res.fired = (res.status == ST_OK);
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.button = cur_btn;
    res.xs = lit_xs;
    res.ys = lit_ys;
    res.xe = lit_xe;
    res.ye = lit_ye;
    res.palette = lit_palette;
    res.stamp = lit_stamp;
    return res;
  endfunction

  function automatic request_t make_req(input logic [REQ_W-1:0] kind,
                                        input logic [BTN_W-1:0] button, up, down, left, right,
                                        input logic [COORD_W-1:0] xs, ys, xe, ye,
                                        input logic [SET_W-1:0] set);
    return '{kind, button, up, down, left, right, xs, ys, xe, ye, set};
  endfunction

  // result before any selection: only the status is set
  function automatic highlight_t status_only(input logic [STATUS_W-1:0] st);
    highlight_t res;
    res = '0;
    res.status = st;
    return res;
  endfunction

  // neighbour link, mostly a valid button number
  function automatic logic [BTN_W-1:0] random_link();
    if ($urandom_range(3) != 0) return BTN_W'($urandom_range(MAX_BUTTONS_DEF, 1));
    return BTN_W'($urandom_range(63));
  endfunction

  // random request, mostly well-formed, with noise in unused fields
  function automatic request_t random_request();
    request_t r;
    int unsigned live, pick, roll, span;
    r = '{REQ_W'($urandom_range(7)), BTN_W'($urandom_range(63)),
          BTN_W'($urandom_range(63)), BTN_W'($urandom_range(63)),
          BTN_W'($urandom_range(63)), BTN_W'($urandom_range(63)),
          COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
          COORD_W'($urandom_range(1023)), COORD_W'($urandom_range(1023)),
          SET_W'($urandom_range(3))};
    live = live_buttons();
    roll = $urandom_range(99);
    if (roll < 15) begin
      r.kind = REQ_LOAD;
      if ($urandom_range(9) != 0) r.button = BTN_W'($urandom_range(MAX_BUTTONS_DEF, 1));
      r.go_up = random_link();
      r.go_down = random_link();
      r.go_left = random_link();
      r.go_right = random_link();
      if ($urandom_range(4) != 0) begin
        span = r.xs + $urandom_range(300);
        r.xe = (span > 1023) ? 10'd1023 : COORD_W'(span);
        span = r.ys + $urandom_range(300);
        r.ye = (span > 1023) ? 10'd1023 : COORD_W'(span);
      end
    end else if (roll < 50) begin
      case ($urandom_range(3))
        0: r.kind = REQ_UP;
        1: r.kind = REQ_DOWN;
        2: r.kind = REQ_LEFT;
        default: r.kind = REQ_RIGHT;
      endcase
    end else if (roll < 65) begin
      r.kind = REQ_SELECT;
      if (live != 0 && $urandom_range(4) != 0) r.button = BTN_W'($urandom_range(live, 1));
    end else if (roll < 85) begin
      r.kind = REQ_POINT;
      if (live != 0 && $urandom_range(3) != 0) begin
        pick = $urandom_range(live, 1);
        if (buttons[pick].xs <= buttons[pick].xe && buttons[pick].ys <= buttons[pick].ye) begin
          r.xs = COORD_W'($urandom_range(buttons[pick].xe, buttons[pick].xs));
          r.ys = COORD_W'($urandom_range(buttons[pick].ye, buttons[pick].ys));
        end
      end
    end else begin
      r.kind = REQ_ACTIVATE;
    end
    return r;
  endfunction

  // one request transaction, expectation queued at acceptance
  task automatic send_request(input request_t r, input bit typed, input highlight_t want);
    highlight_t model;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    button_index <= r.button;
    link_up <= r.go_up;
    link_down <= r.go_down;
    link_left <= r.go_left;
    link_right <= r.go_right;
    box_x_start <= r.xs;
    box_y_start <= r.ys;
    box_x_end <= r.xe;
    box_y_end <= r.ye;
    color_set <= r.set;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = navigate(r);
    awaited_highlights.push_back(typed ? want : model);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_BUTTON_COUNT:  btn_count = data[BTN_W-1:0];
      REG_START_TIME:    start_stamp = data;
      REG_SEL_PAL_ONE:   sel_pal[1] = data;
      REG_SEL_PAL_TWO:   sel_pal[2] = data;
      REG_SEL_PAL_THREE: sel_pal[3] = data;
      REG_ACT_PAL_ONE:   act_pal[1] = data;
      REG_ACT_PAL_TWO:   act_pal[2] = data;
      REG_ACT_PAL_THREE: act_pal[3] = data;
      default: ;
    endcase
  endtask

  // all registers in one go, block must be idle
  task automatic configure(input logic [WORD_W-1:0] count, input logic [WORD_W-1:0] words [8]);
    write_reg(REG_BUTTON_COUNT, count);
    write_reg(REG_START_TIME, words[1]);
    write_reg(REG_SEL_PAL_ONE, words[2]);
    write_reg(REG_SEL_PAL_TWO, words[3]);
    write_reg(REG_SEL_PAL_THREE, words[4]);
    write_reg(REG_ACT_PAL_ONE, words[5]);
    write_reg(REG_ACT_PAL_TWO, words[6]);
    write_reg(REG_ACT_PAL_THREE, words[7]);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_highlights.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    highlight_t seen, due;
    if (!rst && out_valid && !out_stall) begin
      seen = '{status, current_button, hl_x_start, hl_y_start, hl_x_end, hl_y_end,
               hl_palette, hl_time, hl_changed, activated};
      if (awaited_highlights.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", seen);
      end else begin
        due = awaited_highlights.pop_front();
        if (seen !== due) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", due, seen);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t opening [$];
    row_t steering [$];
    logic [WORD_W-1:0] words [8];
    logic [WORD_W-1:0] count;
    int ph, b;

    // straight after reset: no buttons, no highlight
    opening.push_back('{make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_NONE)});
    opening.push_back('{make_req(REQ_UP, 1, 63, 63, 63, 63, 1023, 1023, 1023, 1023, 3), 1'b1,
                        status_only(ST_NONE)});
    opening.push_back('{make_req(REQ_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_NONE)});
    opening.push_back('{make_req(REQ_SELECT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_RANGE)});
    opening.push_back('{make_req(REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_RANGE)});
    opening.push_back('{make_req(REQ_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_OK)});
    // loads outside the table
    opening.push_back('{make_req(REQ_LOAD, 0, 1, 1, 1, 1, 0, 0, 9, 9, 1), 1'b1,
                        status_only(ST_RANGE)});
    opening.push_back('{make_req(REQ_LOAD, 37, 1, 1, 1, 1, 0, 0, 9, 9, 1), 1'b1,
                        status_only(ST_RANGE)});
    opening.push_back('{make_req(REQ_LOAD, 63, 63, 63, 63, 63, 1023, 1023, 1023, 1023, 3), 1'b1,
                        status_only(ST_RANGE)});
    // table entries with extreme boxes and links
    opening.push_back('{make_req(REQ_LOAD, 1, 2, 63, 0, 3, 0, 0, 1023, 1023, 1), 1'b1,
                        status_only(ST_OK)});
    opening.push_back('{make_req(REQ_LOAD, 2, 1, 3, 4, 2, 100, 100, 199, 199, 2), 1'b1,
                        status_only(ST_OK)});
    opening.push_back('{make_req(REQ_LOAD, 3, 63, 63, 63, 63, 1023, 1023, 1023, 1023, 3), 1'b1,
                        status_only(ST_OK)});
    opening.push_back('{make_req(REQ_LOAD, 4, 3, 1, 2, 0, 500, 500, 600, 600, 0), 1'b1,
                        status_only(ST_OK)});
    opening.push_back('{make_req(REQ_LOAD, 36, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        status_only(ST_OK)});

    // navigation with the button count set to four
    steering.push_back('{make_req(REQ_SELECT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_UP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_POINT, 0, 0, 0, 0, 0, 150, 150, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_POINT, 0, 0, 0, 0, 0, 150, 150, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_DOWN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_RIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_LEFT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_SELECT, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_SELECT, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steering.push_back('{make_req(REQ_POINT, 0, 0, 0, 0, 0, 1023, 1023, 0, 0, 0), 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_request(opening[i].rq, opening[i].typed, opening[i].want);
    drain();
    words = '{32'h0, 32'hFFFF_FFFF, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
              32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC};
    configure(4, words);
    foreach (steering[i]) send_request(steering[i].rq, steering[i].typed, steering[i].want);

    // random phases: full, over the cap, mid, one, none, mid
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: count = MAX_BUTTONS_DEF;
        1: count = 63;
        3: count = 1;
        4: count = 0;
        default: count = $urandom_range(MAX_BUTTONS_DEF - 1, 2);
      endcase
      foreach (words[i]) words[i] = (ph == 1) ? '1 : (ph == 4) ? '0 : $urandom();
      configure(count, words);
      idle_pct = (ph == 2) ? 0 : 14;
      // fill every table entry before anything can read it
      if (ph == 0) begin
        for (b = 1; b <= MAX_BUTTONS_DEF; b++) begin
          if (!loaded[b])
            send_request(make_req(REQ_LOAD, BTN_W'(b), random_link(), random_link(),
                                  random_link(), random_link(),
                                  COORD_W'($urandom_range(700)),
                                  COORD_W'($urandom_range(700)),
                                  COORD_W'($urandom_range(1023, 700)),
                                  COORD_W'($urandom_range(1023, 700)),
                                  SET_W'($urandom_range(3))), 1'b0, '0);
        end
      end
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
    end

    drain();
    repeat (60) @(posedge clk);
    errors += awaited_highlights.size();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
